### sv/tdf_pkg.sv
package tdf_pkg;

    // Default operand width of the factorizer
    localparam int WIDTH_DEF = 32;

    // Width of the external value and factor fields
    localparam int FIELD_W = 32;

    // Result limit per request and the width of its counter
    localparam int MAX_RES = 31;
    localparam int CNT_W   = 5;

    // Result status codes
    localparam logic [1:0] ST_FACTOR  = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_value;    // start a new request: remaining, divisor, count
        logic load_special;  // park the result for value zero or one
        logic start_div;     // load the divider from the next remaining value
        logic step;          // run one divider step
        logic advance_div;   // try the next divisor
        logic take_factor;   // divisor divides: park it, keep the quotient
        logic take_tail;     // park the prime left over after the trials
        logic push;          // move the parked result to the output register
        logic push_last;     // last flag for the pushed result
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic trivial;     // input value is zero or one
        logic div_last;    // divider is on its final step
        logic more;        // count below limit and divisor <= quotient
        logic exact;       // divider remainder is zero
        logic tail;        // count below limit and remaining above one
        logic pend_valid;  // a parked result waits
        logic out_free;    // output register can take a result this cycle
    } t_stat;

endpackage

### sv/tdf_datapath.sv
module tdf_datapath #(
    parameter int WIDTH = tdf_pkg::WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tdf_pkg::FIELD_W-1:0]  i_value,
    input  logic                         i_ready,
    input  tdf_pkg::t_cmd                i_cmd,
    output tdf_pkg::t_stat               o_stat,
    output logic                         o_valid,
    output logic [tdf_pkg::FIELD_W-1:0]  o_factor,
    output logic [1:0]                   o_status,
    output logic                         o_last
);

    localparam int                 STEP_W    = $clog2(WIDTH);
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(WIDTH - 1);
    localparam int                 CNT_W     = tdf_pkg::CNT_W;
    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(tdf_pkg::MAX_RES);

    // Working registers
    logic [WIDTH-1:0]            r_rem, n_rem;
    logic [WIDTH-1:0]            r_div, n_div;
    logic [WIDTH-1:0]            r_quo, n_quo;
    logic [WIDTH-1:0]            r_par, n_par;
    logic [STEP_W-1:0]           r_step, n_step;
    logic [CNT_W-1:0]            r_count, n_count;

    // Parked result and output register
    logic                        r_pend_valid, n_pend_valid;
    logic [tdf_pkg::FIELD_W-1:0] r_pend_factor, n_pend_factor;
    logic [1:0]                  r_pend_status, n_pend_status;
    logic                        r_o_valid, n_o_valid;
    logic [tdf_pkg::FIELD_W-1:0] r_o_factor, n_o_factor;
    logic [1:0]                  r_o_status, n_o_status;
    logic                        r_o_last, n_o_last;

    logic [WIDTH-1:0]            value;
    logic [WIDTH:0]              trial;
    logic [WIDTH:0]              diff;
    logic                        fits;

    // Mask or extend the input to the operand width
    assign value = WIDTH'(i_value);

    // Restoring divider step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_par, r_quo[WIDTH-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = (trial >= {1'b0, r_div});

    // Update remaining value and trial divisor
    always_comb begin
        n_rem = r_rem;
        n_div = r_div;
        if (i_cmd.load_value) begin
            n_rem = value;
            n_div = WIDTH'(2);
        end else begin
            if (i_cmd.take_factor) begin
                n_rem = r_quo;
            end
            if (i_cmd.advance_div) begin
                n_div = r_div + WIDTH'(1);
            end
        end
    end

    // Run the divider: quotient builds in r_quo, remainder in r_par
    always_comb begin
        n_par  = r_par;
        n_quo  = r_quo;
        n_step = r_step;
        if (i_cmd.start_div) begin
            n_par  = '0;
            n_quo  = n_rem;
            n_step = '0;
        end else if (i_cmd.step) begin
            n_par  = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            n_quo  = {r_quo[WIDTH-2:0], fits};
            n_step = r_step + STEP_W'(1);
        end
    end

    // Count results and park the newest one
    always_comb begin
        n_count       = r_count;
        n_pend_valid  = r_pend_valid;
        n_pend_factor = r_pend_factor;
        n_pend_status = r_pend_status;
        if (i_cmd.load_value) begin
            n_count      = '0;
            n_pend_valid = 1'b0;
        end
        if (i_cmd.load_special) begin
            n_pend_valid  = 1'b1;
            n_pend_factor = '0;
            n_pend_status = (value == '0) ? tdf_pkg::ST_INVALID : tdf_pkg::ST_NONE;
        end
        if (i_cmd.take_factor) begin
            n_count       = r_count + CNT_W'(1);
            n_pend_valid  = 1'b1;
            n_pend_factor = tdf_pkg::FIELD_W'(r_div);
            n_pend_status = tdf_pkg::ST_FACTOR;
        end
        if (i_cmd.take_tail) begin
            n_count       = r_count + CNT_W'(1);
            n_pend_valid  = 1'b1;
            n_pend_factor = tdf_pkg::FIELD_W'(r_rem);
            n_pend_status = tdf_pkg::ST_FACTOR;
        end
    end

    // Load the output register on push, drop valid once taken
    always_comb begin
        n_o_valid  = r_o_valid;
        n_o_factor = r_o_factor;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        if (i_cmd.push) begin
            n_o_valid  = 1'b1;
            n_o_factor = r_pend_factor;
            n_o_status = r_pend_status;
            n_o_last   = i_cmd.push_last;
        end else if (i_ready) begin
            n_o_valid  = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem        <= '0;
            r_div        <= WIDTH'(2);
            r_step       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_rem        <= n_rem;
            r_div        <= n_div;
            r_step       <= n_step;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_quo         <= n_quo;
        r_par         <= n_par;
        r_pend_factor <= n_pend_factor;
        r_pend_status <= n_pend_status;
        r_o_factor    <= n_o_factor;
        r_o_status    <= n_o_status;
        r_o_last      <= n_o_last;
    end

    // Report status to the controller
    always_comb begin
        o_stat.trivial    = (value == '0) || (value == WIDTH'(1));
        o_stat.div_last   = (r_step == STEP_LAST);
        o_stat.more       = (r_count < CNT_MAX) && (r_div <= r_quo);
        o_stat.exact      = (r_par == '0);
        o_stat.tail       = (r_count < CNT_MAX) && (r_rem > WIDTH'(1));
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = !r_o_valid || i_ready;
    end

    assign o_valid  = r_o_valid;
    assign o_factor = r_o_factor;
    assign o_status = r_o_status;
    assign o_last   = r_o_last;

endmodule

### sv/tdf_ctrl.sv
module tdf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tdf_pkg::t_stat i_stat,
    output tdf_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] r_state, n_state;

    // Sequence one request: divide, check, park factors, flush the last one
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_stat.trivial) begin
                        o_cmd.load_special = 1'b1;
                        n_state            = S_FLUSH;
                    end else begin
                        o_cmd.load_value = 1'b1;
                        o_cmd.start_div  = 1'b1;
                        n_state          = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.more) begin
                    if (!i_stat.exact) begin
                        o_cmd.advance_div = 1'b1;
                        o_cmd.start_div   = 1'b1;
                        n_state           = S_DIV;
                    end else if (!i_stat.pend_valid || i_stat.out_free) begin
                        // Release the previous factor, park this one
                        o_cmd.push        = i_stat.pend_valid;
                        o_cmd.take_factor = 1'b1;
                        o_cmd.start_div   = 1'b1;
                        n_state           = S_DIV;
                    end
                end else if (i_stat.tail) begin
                    if (!i_stat.pend_valid || i_stat.out_free) begin
                        o_cmd.push      = i_stat.pend_valid;
                        o_cmd.take_tail = 1'b1;
                        n_state         = S_FLUSH;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/trial_division_factorizer.sv
// Trial-division factorizer: takes one unsigned value per request and returns its prime
// factors in ascending order, one result per factor with repeats, the final one marked by
// o_last. Value one gives a single result with status "no factors", value zero a single
// result with status "invalid", both with factor 0. Every trial divisor costs one pass of
// a bit-serial restoring divider plus one check, and each factor found costs one more
// pass, so for 32-bit values the worst case, a prime near 2^32, is about 65536 trials.
// One request is worked on at a time; o_ready returns once the final result sits in the
// output register, and a stalled output consumer holds the divider loop at the point
// where the next result is due.
module trial_division_factorizer #(
    parameter int WIDTH = tdf_pkg::WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tdf_pkg::FIELD_W-1:0]  i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tdf_pkg::FIELD_W-1:0]  o_factor,
    output logic [1:0]                   o_status,
    output logic                         o_last
);

    tdf_pkg::t_cmd  cmd;
    tdf_pkg::t_stat stat;

    tdf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tdf_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_ready  (i_ready),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_factor (o_factor),
        .o_status (o_status),
        .o_last   (o_last)
    );

endmodule

### sv/tdf_checker.sv
module tdf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [tdf_pkg::FIELD_W-1:0]  i_value,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [tdf_pkg::FIELD_W-1:0]  o_factor,
    input logic [1:0]                   o_status,
    input logic                         o_last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_factor) && $stable(o_status)
                                && $stable(o_last))
        else $error("stalled result changed");

    // Close a request on a special status
    a_special_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != tdf_pkg::ST_FACTOR) |-> o_last)
        else $error("special status without last");

    // Report zero factor with a special status
    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != tdf_pkg::ST_FACTOR) |-> (o_factor == '0))
        else $error("special status with nonzero factor");

    // Drop ready after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held after accepting a request");

endmodule

bind trial_division_factorizer tdf_checker u_tdf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_value  (i_value),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_factor (o_factor),
    .o_status (o_status),
    .o_last   (o_last)
);

### test/factor_checker.sv
`timescale 1ns / 100ps

// Watch both channels of the factorizer, predict the prime factors of every accepted
// request and compare each returned result against the oldest one still owed.
module factor_checker #(
    parameter int WIDTH = tdf_pkg::WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic [tdf_pkg::FIELD_W-1:0] i_value,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic [tdf_pkg::FIELD_W-1:0] i_factor,
    input  logic [1:0]                  i_status,
    input  logic                        i_last,
    output int                          o_mismatches,
    output int                          o_pending
);

    localparam logic [63:0] VALUE_MASK = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
    localparam int          REPORT_MAX = 10;

    typedef struct packed {
        logic [tdf_pkg::FIELD_W-1:0] factor;
        logic [1:0]                  status;
        logic                        last;
    } t_factor_result;

    t_factor_result expected_factors[$];
    int             mismatch_count = 0;
    int             pending_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    // Factor one request by trial division and queue the results it owes
    function automatic void predict_factors(input logic [tdf_pkg::FIELD_W-1:0] value);
        logic [63:0]    rest;
        logic [63:0]    trial;
        logic [63:0]    found_list[tdf_pkg::MAX_RES];
        int             found;
        t_factor_result res;
        rest = 64'(value) & VALUE_MASK;
        if (rest < 64'd2) begin
            res.factor = '0;
            res.status = (rest == 64'd0) ? tdf_pkg::ST_INVALID : tdf_pkg::ST_NONE;
            res.last   = 1'b1;
            expected_factors = {expected_factors, res};
        end else begin
            found = 0;
            trial = 64'd2;
            while (found < tdf_pkg::MAX_RES && trial <= rest / trial) begin
                if (rest % trial == 64'd0) begin
                    found_list[found] = trial;
                    found++;
                    rest = rest / trial;
                end else begin
                    trial++;
                end
            end
            // whatever survives the trials is itself prime
            if (found < tdf_pkg::MAX_RES && rest > 64'd1) begin
                found_list[found] = rest;
                found++;
            end
            for (int k = 0; k < found; k++) begin
                res.factor = found_list[k][tdf_pkg::FIELD_W-1:0];
                res.status = tdf_pkg::ST_FACTOR;
                res.last   = (k == found - 1);
                expected_factors = {expected_factors, res};
            end
        end
    endfunction

    // Check returned results first, then queue predictions for a new request
    always @(posedge i_clk) begin
        t_factor_result want;
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (expected_factors.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("%t: unexpected result factor=%0d status=%0d last=%0d",
                                 $realtime, i_factor, i_status, i_last);
                    end
                end else begin
                    want = expected_factors.pop_front();
                    if (want.factor !== i_factor || want.status !== i_status
                            || want.last !== i_last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display({"%t: expected factor=%0d status=%0d last=%0d,",
                                      " got %0d %0d %0d"},
                                     $realtime, want.factor, want.status, want.last,
                                     i_factor, i_status, i_last);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_factors(i_value);
            end
        end
        pending_count = expected_factors.size();
    end

endmodule

### test/trial_division_factorizer_test.sv
`timescale 1ns / 100ps

module trial_division_factorizer_test;

    localparam int IDLE_LIMIT   = 100000;
    localparam int RANDOM_ITEMS = 80;
    localparam int DRAIN_CYCLES = 50;

    // Extremes, repeated factors, a prime square and a prime remainder
    localparam logic [tdf_pkg::FIELD_W-1:0] DIRECTED_VALUES[18] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd97, 32'd1024,
        32'd30030, 32'd63001, 32'd65521, 32'h8000_0000, 32'hFFFF_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000, 32'd3486784401, 32'd2147483646
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [tdf_pkg::FIELD_W-1:0] i_value;
    logic                        o_valid;
    logic                        i_ready;
    logic [tdf_pkg::FIELD_W-1:0] o_factor;
    logic [1:0]                  o_status;
    logic                        o_last;

    int send_idle_pct = 29;
    int recv_idle_pct = 82;
    int idle_cycles   = 0;
    int mismatches;
    int pending;

    trial_division_factorizer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_factor (o_factor),
        .o_status (o_status),
        .o_last   (o_last)
    );

    factor_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_value      (i_value),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_factor     (o_factor),
        .i_status     (o_status),
        .i_last       (o_last),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stall the result side at random
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("trial_division_factorizer_test failed");
            $finish;
        end
    end

    // Mostly products of small factors, so every request stays cheap to factor
    function automatic logic [tdf_pkg::FIELD_W-1:0] random_value();
        logic [63:0] product;
        logic [63:0] next;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            product = 64'd1;
            do begin
                next = product * 64'($urandom_range(300, 2));
                if (next <= 64'hFFFF_FFFF) begin
                    product = next;
                end
            end while (next <= 64'hFFFF_FFFF && $urandom_range(5) != 0);
            return product[tdf_pkg::FIELD_W-1:0];
        end
        if (pick < 85) begin
            return tdf_pkg::FIELD_W'($urandom_range(65535));
        end
        if (pick < 92) begin
            return tdf_pkg::FIELD_W'($urandom_range(1));
        end
        return tdf_pkg::FIELD_W'($urandom_range(255, 1)) << $urandom_range(24);
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input logic [tdf_pkg::FIELD_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off until every owed result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_VALUES[k]) begin
            send_request(DIRECTED_VALUES[k]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // swap the idling sides, then drop idling altogether
            if (n == RANDOM_ITEMS / 3) begin
                wait_drained();
                send_idle_pct = 82;
                recv_idle_pct = 29;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                wait_drained();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_request(random_value());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("trial_division_factorizer_test passed");
        end else begin
            $display("trial_division_factorizer_test failed");
        end
        $finish;
    end

endmodule

### files.f
sv/tdf_pkg.sv
sv/tdf_datapath.sv
sv/tdf_ctrl.sv
sv/trial_division_factorizer.sv
sv/tdf_checker.sv
test/factor_checker.sv
test/trial_division_factorizer_test.sv
